>>> design/kams_pkg.sv
// Package for the keyed adjacency matrix store.
// Holds sizes, operation and status codes, word types and internal command structs.
// No dependencies.
package kams_pkg;

    localparam int MAX_V     = 16;
    localparam int V_BITS    = 4;
    localparam int N_BITS    = 5;
    localparam int KEY_BITS  = 32;
    localparam int W_BITS    = 16;
    localparam int ADDR_BITS = 2 * V_BITS;
    localparam int CELLS     = MAX_V * MAX_V;

    localparam logic [2:0] OP_INS_EDGE = 3'd0;
    localparam logic [2:0] OP_INS_VTX  = 3'd1;
    localparam logic [2:0] OP_ERS_EDGE = 3'd2;
    localparam logic [2:0] OP_ERS_VTX  = 3'd3;
    localparam logic [2:0] OP_LOOKUP   = 3'd4;
    localparam logic [2:0] OP_LIST     = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_NO_FREE   = 2'd2;

    localparam logic signed [W_BITS-1:0] NO_EDGE_RESET = 16'sd32767;

    typedef struct packed {
        logic [2:0]                 operation;
        logic [KEY_BITS-1:0]        key_a;
        logic [KEY_BITS-1:0]        key_b;
        logic signed [W_BITS-1:0]   edge_weight;
    } t_in_word;

    typedef struct packed {
        logic [1:0]                 status;
        logic [N_BITS-1:0]          number_a;
        logic [N_BITS-1:0]          number_b;
        logic                       has_neighbour;
        logic [KEY_BITS-1:0]        neighbour_key;
        logic signed [W_BITS-1:0]   neighbour_weight;
        logic                       last;
    } t_out_word;

    // Commands to the weight memory.
    typedef struct packed {
        logic                       wr;
        logic                       clr_all;
        logic                       clr_vtx;
        logic [V_BITS-1:0]          vtx;
        logic [ADDR_BITS-1:0]       wr_addr;
        logic signed [W_BITS-1:0]   wr_data;
    } t_wm_cmd;

    // Commands to the vertex table.
    typedef struct packed {
        logic                       take;
        logic [KEY_BITS-1:0]        take_key;
        logic                       drop;
        logic [N_BITS-1:0]          drop_num;
    } t_vt_cmd;

endpackage

>>> design/keyed_adjacency_matrix_store.sv
// Keyed adjacency matrix store: a directed weighted graph of up to 16 vertices
// named by 32-bit keys, with edge weights held in a 256-entry synchronous memory.
// Input channel: i_in_valid / o_in_ready carry one request word (operation, keys,
// weight). Output channel: o_out_valid / i_out_ready carry result words.
// One request is worked on at a time; o_in_ready is high only while the block is idle.
// Lookup, erase edge and erase vertex give their single result straight from the
// execute state. Insert vertex and insert edge take each new vertex number from
// the free list in a step of its own; insert edge first checks that enough numbers
// are free and, if not, is rejected without taking any number.
// List row walks the row through the memory's single read port, with a read state
// and an evaluate state per column, giving one word per neighbour (or one empty
// word if there is none) and marking the final word with last.
// A held result word does not block the next acceptance; work stalls only when a
// new word must be emitted while the output register is still full.
// Writing i_cfg_data with i_cfg_we (only while idle) sets the no-edge weight and
// refills the matrix at once by clearing per-entry valid bits.
// Reset (synchronous, active low) empties the vertex table, restores the free list
// to 1..16 and the no-edge weight to 32767; no clearing pass is needed.
module keyed_adjacency_matrix_store (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  kams_pkg::t_in_word                  i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output kams_pkg::t_out_word                 o_out_word,
    input  logic                                i_cfg_we,
    input  logic signed [kams_pkg::W_BITS-1:0]  i_cfg_data
);

    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_LREAD, S_LEVAL, S_LDONE} t_state;

    t_state                              r_state, n_state;
    kams_pkg::t_in_word                  r_req, n_req;
    kams_pkg::t_out_word                 r_out, n_out;
    logic                                r_out_vld, n_out_vld;
    logic                                r_chk, n_chk;
    logic [kams_pkg::V_BITS-1:0]         r_row, n_row;
    logic [kams_pkg::V_BITS-1:0]         r_col, n_col;
    kams_pkg::t_out_word                 r_pend, n_pend;
    logic                                r_pend_vld, n_pend_vld;
    logic signed [kams_pkg::W_BITS-1:0]  r_no_edge;

    kams_pkg::t_wm_cmd                   w_wm_cmd;
    kams_pkg::t_vt_cmd                   w_vt_cmd;
    logic [kams_pkg::N_BITS-1:0]         w_na, w_nb, w_free_cnt;
    logic [kams_pkg::KEY_BITS-1:0]       w_rd_key;
    logic                                w_rd_vld;
    logic signed [kams_pkg::W_BITS-1:0]  w_rd_weight;
    logic                                w_out_free;
    logic [1:0]                          w_need;
    logic                                w_hit;
    logic [kams_pkg::V_BITS-1:0]         w_ia, w_ib;

    function automatic kams_pkg::t_out_word mk_out(
        input logic [1:0]                 st,
        input logic [kams_pkg::N_BITS-1:0] na,
        input logic [kams_pkg::N_BITS-1:0] nb
    );
        kams_pkg::t_out_word o;
        o          = '0;
        o.status   = st;
        o.number_a = na;
        o.number_b = nb;
        o.last     = 1'b1;
        return o;
    endfunction

    kams_wmem u_wmem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_wm_cmd),
        .i_rd_addr   ({r_row, r_col}),
        .i_no_edge   (r_no_edge),
        .o_rd_weight (w_rd_weight)
    );

    kams_vtab u_vtab (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_vt_cmd),
        .i_key_a    (r_req.key_a),
        .i_key_b    (r_req.key_b),
        .i_rd_idx   (r_col),
        .o_num_a    (w_na),
        .o_num_b    (w_nb),
        .o_rd_key   (w_rd_key),
        .o_rd_vld   (w_rd_vld),
        .o_free_cnt (w_free_cnt)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;
    assign w_out_free  = !r_out_vld || i_out_ready;
    assign w_ia        = kams_pkg::V_BITS'(w_na - kams_pkg::N_BITS'(1));
    assign w_ib        = kams_pkg::V_BITS'(w_nb - kams_pkg::N_BITS'(1));

    always_comb begin
        w_need = 2'((w_na == '0) ? 1 : 0) + 2'((w_nb == '0) ? 1 : 0);
        if (w_na == '0 && w_nb == '0 && r_req.key_a == r_req.key_b) begin
            w_need = 2'd1;
        end
        w_hit = w_rd_vld && (w_rd_weight != '0) && (w_rd_weight < r_no_edge);
    end

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_out      = r_out;
        n_out_vld  = r_out_vld && !i_out_ready;
        n_chk      = r_chk;
        n_row      = r_row;
        n_col      = r_col;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        w_wm_cmd   = '0;
        w_wm_cmd.clr_all = i_cfg_we;
        w_vt_cmd   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_word;
                    n_chk   = 1'b0;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_req.operation)
                    kams_pkg::OP_INS_EDGE: begin
                        if (!r_chk) begin
                            if (kams_pkg::N_BITS'(w_need) > w_free_cnt) begin
                                if (w_out_free) begin
                                    n_out     = mk_out(kams_pkg::ST_NO_FREE, w_na, w_nb);
                                    n_out_vld = 1'b1;
                                    n_state   = S_IDLE;
                                end
                            end else begin
                                n_chk = 1'b1;
                            end
                        end else if (w_na == '0) begin
                            w_vt_cmd.take     = 1'b1;
                            w_vt_cmd.take_key = r_req.key_a;
                        end else if (w_nb == '0) begin
                            w_vt_cmd.take     = 1'b1;
                            w_vt_cmd.take_key = r_req.key_b;
                        end else if (w_out_free) begin
                            w_wm_cmd.wr      = 1'b1;
                            w_wm_cmd.wr_addr = {w_ia, w_ib};
                            w_wm_cmd.wr_data = r_req.edge_weight;
                            n_out     = mk_out(kams_pkg::ST_OK, w_na, w_nb);
                            n_out_vld = 1'b1;
                            n_state   = S_IDLE;
                        end
                    end
                    kams_pkg::OP_INS_VTX: begin
                        if (w_na != '0) begin
                            if (w_out_free) begin
                                n_out     = mk_out(kams_pkg::ST_OK, w_na, '0);
                                n_out_vld = 1'b1;
                                n_state   = S_IDLE;
                            end
                        end else if (w_free_cnt == '0) begin
                            if (w_out_free) begin
                                n_out     = mk_out(kams_pkg::ST_NO_FREE, '0, '0);
                                n_out_vld = 1'b1;
                                n_state   = S_IDLE;
                            end
                        end else begin
                            w_vt_cmd.take     = 1'b1;
                            w_vt_cmd.take_key = r_req.key_a;
                        end
                    end
                    kams_pkg::OP_ERS_EDGE: begin
                        if (w_out_free) begin
                            if (w_na == '0 || w_nb == '0) begin
                                n_out = mk_out(kams_pkg::ST_NOT_FOUND, w_na, w_nb);
                            end else begin
                                w_wm_cmd.wr      = 1'b1;
                                w_wm_cmd.wr_addr = {w_ia, w_ib};
                                w_wm_cmd.wr_data = r_no_edge;
                                n_out = mk_out(kams_pkg::ST_OK, w_na, w_nb);
                            end
                            n_out_vld = 1'b1;
                            n_state   = S_IDLE;
                        end
                    end
                    kams_pkg::OP_ERS_VTX: begin
                        if (w_out_free) begin
                            if (w_na == '0) begin
                                n_out = mk_out(kams_pkg::ST_NOT_FOUND, '0, '0);
                            end else begin
                                w_wm_cmd.clr_vtx  = 1'b1;
                                w_wm_cmd.vtx      = w_ia;
                                w_vt_cmd.drop     = 1'b1;
                                w_vt_cmd.drop_num = w_na;
                                n_out = mk_out(kams_pkg::ST_OK, w_na, '0);
                            end
                            n_out_vld = 1'b1;
                            n_state   = S_IDLE;
                        end
                    end
                    kams_pkg::OP_LOOKUP: begin
                        if (w_out_free) begin
                            n_out = mk_out((w_na == '0) ? kams_pkg::ST_NOT_FOUND
                                                        : kams_pkg::ST_OK, w_na, '0);
                            n_out_vld = 1'b1;
                            n_state   = S_IDLE;
                        end
                    end
                    kams_pkg::OP_LIST: begin
                        if (w_na == '0) begin
                            if (w_out_free) begin
                                n_out     = mk_out(kams_pkg::ST_NOT_FOUND, '0, '0);
                                n_out_vld = 1'b1;
                                n_state   = S_IDLE;
                            end
                        end else begin
                            n_row      = w_ia;
                            n_col      = '0;
                            n_pend_vld = 1'b0;
                            n_state    = S_LREAD;
                        end
                    end
                    default: begin
                        if (w_out_free) begin
                            n_out        = '0;
                            n_out.last   = 1'b1;
                            n_out_vld    = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                endcase
            end
            S_LREAD: begin
                n_state = S_LEVAL;
            end
            S_LEVAL: begin
                // A hit is kept pending so the final word can carry last.
                if (!(w_hit && r_pend_vld && !w_out_free)) begin
                    if (w_hit) begin
                        if (r_pend_vld) begin
                            n_out     = r_pend;
                            n_out_vld = 1'b1;
                        end
                        n_pend                  = mk_out(kams_pkg::ST_OK,
                                                         kams_pkg::N_BITS'(r_row)
                                                         + kams_pkg::N_BITS'(1), '0);
                        n_pend.last             = 1'b0;
                        n_pend.has_neighbour    = 1'b1;
                        n_pend.neighbour_key    = w_rd_key;
                        n_pend.neighbour_weight = w_rd_weight;
                        n_pend_vld              = 1'b1;
                    end
                    if (r_col == kams_pkg::V_BITS'(kams_pkg::MAX_V - 1)) begin
                        n_state = S_LDONE;
                    end else begin
                        n_col   = r_col + kams_pkg::V_BITS'(1);
                        n_state = S_LREAD;
                    end
                end
            end
            S_LDONE: begin
                if (w_out_free) begin
                    if (r_pend_vld) begin
                        n_out      = r_pend;
                        n_out.last = 1'b1;
                    end else begin
                        n_out = mk_out(kams_pkg::ST_OK,
                                       kams_pkg::N_BITS'(r_row) + kams_pkg::N_BITS'(1), '0);
                    end
                    n_out_vld  = 1'b1;
                    n_pend_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_chk      <= 1'b0;
            r_no_edge  <= kams_pkg::NO_EDGE_RESET;
        end else begin
            r_state    <= n_state;
            r_out_vld  <= n_out_vld;
            r_pend_vld <= n_pend_vld;
            r_chk      <= n_chk;
            if (i_cfg_we) begin
                r_no_edge <= i_cfg_data;
            end
        end
        r_req  <= n_req;
        r_out  <= n_out;
        r_row  <= n_row;
        r_col  <= n_col;
        r_pend <= n_pend;
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("block accepted a word while still busy");

    a_free_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_free_cnt <= kams_pkg::N_BITS'(kams_pkg::MAX_V))
        else $error("free list count above vertex count");

    a_neighbour_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.has_neighbour) |->
            (r_out.status == kams_pkg::ST_OK && r_out.number_a != '0))
        else $error("neighbour word without a valid source vertex");

    a_list_pending_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_vld)
        else $error("pending neighbour word left behind at idle");

endmodule

>>> design/kams_wmem.sv
// Weight matrix memory with one registered read port and one write port.
// Per-entry valid bits stand in for refills; an invalid entry reads as zero on the diagonal, else as i_no_edge.
// Depends on kams_pkg.
module kams_wmem (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  kams_pkg::t_wm_cmd                    i_cmd,
    input  logic [kams_pkg::ADDR_BITS-1:0]       i_rd_addr,
    input  logic signed [kams_pkg::W_BITS-1:0]   i_no_edge,
    output logic signed [kams_pkg::W_BITS-1:0]   o_rd_weight
);

    logic signed [kams_pkg::W_BITS-1:0] r_mem [kams_pkg::CELLS];
    logic [kams_pkg::CELLS-1:0]         r_vld;
    logic signed [kams_pkg::W_BITS-1:0] r_rd_data;
    logic                               r_rd_vld;
    logic                               r_rd_diag;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
        r_rd_diag <= (i_rd_addr[kams_pkg::ADDR_BITS-1:kams_pkg::V_BITS]
                      == i_rd_addr[kams_pkg::V_BITS-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[i_rd_addr];
            if (i_cmd.clr_all) begin
                r_vld <= '0;
            end else begin
                if (i_cmd.clr_vtx) begin
                    for (int k = 0; k < kams_pkg::MAX_V; k++) begin
                        r_vld[{i_cmd.vtx, kams_pkg::V_BITS'(k)}] <= 1'b0;
                        r_vld[{kams_pkg::V_BITS'(k), i_cmd.vtx}] <= 1'b0;
                    end
                end
                if (i_cmd.wr) begin
                    r_vld[i_cmd.wr_addr] <= 1'b1;
                end
            end
        end
    end

    assign o_rd_weight = r_rd_vld ? r_rd_data : (r_rd_diag ? '0 : i_no_edge);

endmodule

>>> design/kams_vtab.sv
// Vertex table: keys, valid flags, key match and the FIFO free list of vertex numbers.
// Depends on kams_pkg.
module kams_vtab (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  kams_pkg::t_vt_cmd                   i_cmd,
    input  logic [kams_pkg::KEY_BITS-1:0]       i_key_a,
    input  logic [kams_pkg::KEY_BITS-1:0]       i_key_b,
    input  logic [kams_pkg::V_BITS-1:0]         i_rd_idx,
    output logic [kams_pkg::N_BITS-1:0]         o_num_a,
    output logic [kams_pkg::N_BITS-1:0]         o_num_b,
    output logic [kams_pkg::KEY_BITS-1:0]       o_rd_key,
    output logic                                o_rd_vld,
    output logic [kams_pkg::N_BITS-1:0]         o_free_cnt
);

    logic [kams_pkg::KEY_BITS-1:0] r_keys [kams_pkg::MAX_V];
    logic [kams_pkg::MAX_V-1:0]    r_vvld;
    logic [kams_pkg::N_BITS-1:0]   r_free [kams_pkg::MAX_V];
    logic [kams_pkg::V_BITS-1:0]   r_head;
    logic [kams_pkg::V_BITS-1:0]   r_tail;
    logic [kams_pkg::N_BITS-1:0]   r_cnt;
    logic [kams_pkg::N_BITS-1:0]   w_take_num;
    logic [kams_pkg::V_BITS-1:0]   w_take_idx;
    logic [kams_pkg::V_BITS-1:0]   w_drop_idx;
    logic                          w_push;

    // Lowest matching slot wins.
    always_comb begin
        o_num_a = '0;
        o_num_b = '0;
        for (int i = kams_pkg::MAX_V - 1; i >= 0; i--) begin
            if (r_vvld[i] && r_keys[i] == i_key_a) begin
                o_num_a = kams_pkg::N_BITS'(i + 1);
            end
            if (r_vvld[i] && r_keys[i] == i_key_b) begin
                o_num_b = kams_pkg::N_BITS'(i + 1);
            end
        end
    end

    always_comb begin
        w_take_num = r_free[r_head];
        if (w_take_num == '0 || w_take_num > kams_pkg::N_BITS'(kams_pkg::MAX_V)) begin
            w_take_num = kams_pkg::N_BITS'(1);
        end
        w_take_idx = kams_pkg::V_BITS'(w_take_num - kams_pkg::N_BITS'(1));
        w_drop_idx = kams_pkg::V_BITS'(i_cmd.drop_num - kams_pkg::N_BITS'(1));
        w_push     = i_cmd.drop && (r_cnt < kams_pkg::N_BITS'(kams_pkg::MAX_V));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_keys[w_take_idx] <= i_cmd.take_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vvld <= '0;
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= kams_pkg::N_BITS'(kams_pkg::MAX_V);
            for (int i = 0; i < kams_pkg::MAX_V; i++) begin
                r_free[i] <= kams_pkg::N_BITS'(i + 1);
            end
        end else begin
            if (i_cmd.take) begin
                r_vvld[w_take_idx] <= 1'b1;
                r_head             <= r_head + kams_pkg::V_BITS'(1);
                r_cnt              <= r_cnt - kams_pkg::N_BITS'(1);
            end else if (i_cmd.drop) begin
                r_vvld[w_drop_idx] <= 1'b0;
                if (w_push) begin
                    r_free[r_tail] <= i_cmd.drop_num;
                    r_tail         <= r_tail + kams_pkg::V_BITS'(1);
                    r_cnt          <= r_cnt + kams_pkg::N_BITS'(1);
                end
            end
        end
    end

    assign o_rd_key   = r_keys[i_rd_idx];
    assign o_rd_vld   = r_vvld[i_rd_idx];
    assign o_free_cnt = r_cnt;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the keyed adjacency matrix store.
// Drives request words through a queue-fed driver, predicts result words with a
// behavioral graph model and checks them in a monitor. Depends on kams_pkg and keyed_adjacency_matrix_store.
module testbench;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    kams_pkg::t_in_word   i_in_word;
    logic                 o_out_valid;
    logic                 i_out_ready;
    kams_pkg::t_out_word  o_out_word;
    logic                 i_cfg_we;
    logic signed [kams_pkg::W_BITS-1:0] i_cfg_data;

    keyed_adjacency_matrix_store u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_word(o_out_word),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    // Graph model state.
    logic signed [kams_pkg::W_BITS-1:0] g_no_edge;
    logic signed [kams_pkg::W_BITS-1:0] g_weight [kams_pkg::MAX_V][kams_pkg::MAX_V];
    logic [kams_pkg::KEY_BITS-1:0]      g_key [kams_pkg::MAX_V];
    logic                               g_valid [kams_pkg::MAX_V];
    logic [kams_pkg::N_BITS-1:0]        g_free [kams_pkg::MAX_V];
    int                                 g_head, g_tail, g_count;

    kams_pkg::t_in_word   pending_words [$];
    kams_pkg::t_out_word  expected_words [$];
    logic [kams_pkg::KEY_BITS-1:0] used_keys [$];

    int  mismatches = 0;
    int  words_sent = 0;
    int  words_seen = 0;
    int  list_hits = 0;
    int  idle_cycles = 0;
    bit  calm = 0;
    bit  hold_send = 0;
    int  send_gap = 0;
    int  recv_gap = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int find_vertex(logic [kams_pkg::KEY_BITS-1:0] k);
        for (int i = 0; i < kams_pkg::MAX_V; i++) begin
            if (g_valid[i] && g_key[i] == k) return i + 1;
        end
        return 0;
    endfunction

    function automatic void refill_matrix();
        for (int i = 0; i < kams_pkg::MAX_V; i++) begin
            for (int j = 0; j < kams_pkg::MAX_V; j++) begin
                g_weight[i][j] = (i == j) ? '0 : g_no_edge;
            end
        end
    endfunction

    function automatic int claim_number(logic [kams_pkg::KEY_BITS-1:0] k);
        int n;
        n = int'(g_free[g_head]);
        g_head = (g_head + 1) % kams_pkg::MAX_V;
        g_count--;
        g_key[n-1] = k;
        g_valid[n-1] = 1'b1;
        return n;
    endfunction

    function automatic kams_pkg::t_out_word result_word(logic [1:0] st, int na, int nb);
        kams_pkg::t_out_word r;
        r = '0;
        r.status = st;
        r.number_a = kams_pkg::N_BITS'(na);
        r.number_b = kams_pkg::N_BITS'(nb);
        r.last = 1'b1;
        return r;
    endfunction

    // Applies one request to the graph model and queues the words it yields.
    function automatic void apply_request(kams_pkg::t_in_word w);
        int na, nb, need, hits;
        kams_pkg::t_out_word r;
        na = find_vertex(w.key_a);
        nb = find_vertex(w.key_b);
        case (w.operation)
            kams_pkg::OP_INS_EDGE: begin
                need = (na == 0 ? 1 : 0) + (nb == 0 ? 1 : 0);
                if (na == 0 && nb == 0 && w.key_a == w.key_b) need = 1;
                if (need > g_count) begin
                    expected_words.push_back(result_word(kams_pkg::ST_NO_FREE, na, nb));
                end else begin
                    if (na == 0) na = claim_number(w.key_a);
                    if (nb == 0) nb = (w.key_a == w.key_b) ? na : claim_number(w.key_b);
                    g_weight[na-1][nb-1] = w.edge_weight;
                    expected_words.push_back(result_word(kams_pkg::ST_OK, na, nb));
                end
            end
            kams_pkg::OP_INS_VTX: begin
                if (na == 0 && g_count == 0) begin
                    expected_words.push_back(result_word(kams_pkg::ST_NO_FREE, 0, 0));
                end else begin
                    if (na == 0) na = claim_number(w.key_a);
                    expected_words.push_back(result_word(kams_pkg::ST_OK, na, 0));
                end
            end
            kams_pkg::OP_ERS_EDGE: begin
                if (na == 0 || nb == 0) begin
                    expected_words.push_back(result_word(kams_pkg::ST_NOT_FOUND, na, nb));
                end else begin
                    g_weight[na-1][nb-1] = g_no_edge;
                    expected_words.push_back(result_word(kams_pkg::ST_OK, na, nb));
                end
            end
            kams_pkg::OP_ERS_VTX: begin
                if (na == 0) begin
                    expected_words.push_back(result_word(kams_pkg::ST_NOT_FOUND, 0, 0));
                end else begin
                    for (int i = 0; i < kams_pkg::MAX_V; i++) begin
                        g_weight[na-1][i] = g_no_edge;
                        g_weight[i][na-1] = g_no_edge;
                    end
                    g_weight[na-1][na-1] = '0;
                    g_valid[na-1] = 1'b0;
                    g_key[na-1] = '0;
                    if (g_count < kams_pkg::MAX_V) begin
                        g_free[g_tail] = kams_pkg::N_BITS'(na);
                        g_tail = (g_tail + 1) % kams_pkg::MAX_V;
                        g_count++;
                    end
                    expected_words.push_back(result_word(kams_pkg::ST_OK, na, 0));
                end
            end
            kams_pkg::OP_LOOKUP: begin
                expected_words.push_back(result_word(na == 0 ? kams_pkg::ST_NOT_FOUND
                                                             : kams_pkg::ST_OK, na, 0));
            end
            kams_pkg::OP_LIST: begin
                if (na == 0) begin
                    expected_words.push_back(result_word(kams_pkg::ST_NOT_FOUND, 0, 0));
                end else begin
                    hits = 0;
                    for (int j = 0; j < kams_pkg::MAX_V; j++) begin
                        if (g_valid[j] && g_weight[na-1][j] != '0
                                && g_weight[na-1][j] < g_no_edge) begin
                            r = result_word(kams_pkg::ST_OK, na, 0);
                            r.has_neighbour = 1'b1;
                            r.neighbour_key = g_key[j];
                            r.neighbour_weight = g_weight[na-1][j];
                            r.last = 1'b0;
                            expected_words.push_back(r);
                            hits++;
                        end
                    end
                    if (hits == 0) expected_words.push_back(result_word(kams_pkg::ST_OK, na, 0));
                    else expected_words[$].last = 1'b1;
                    list_hits += hits;
                end
            end
            default: expected_words.push_back(result_word(kams_pkg::ST_OK, 0, 0));
        endcase
    endfunction

    // Driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) begin
                apply_request(i_in_word);
                words_sent++;
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                send_gap <= $urandom_range(1, 7);
                i_in_valid <= 1'b0;
            end else if (pending_words.size() > 0 && !hold_send) begin
                i_in_word <= pending_words.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor and checker.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                words_seen++;
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word %p", o_out_word);
                end else if (o_out_word !== expected_words[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", expected_words[0], o_out_word);
                    void'(expected_words.pop_front());
                end else begin
                    void'(expected_words.pop_front());
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                recv_gap <= $urandom_range(1, 7);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no accepted word on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("keyed_adjacency_matrix_store test failed");
                $finish;
            end
        end
    end

    function automatic kams_pkg::t_in_word make_word(logic [2:0] op,
                                                     logic [kams_pkg::KEY_BITS-1:0] ka,
                                                     logic [kams_pkg::KEY_BITS-1:0] kb,
                                                     logic [kams_pkg::W_BITS-1:0] w);
        kams_pkg::t_in_word r;
        r.operation = op;
        r.key_a = ka;
        r.key_b = kb;
        r.edge_weight = w;
        return r;
    endfunction

    function automatic logic [kams_pkg::KEY_BITS-1:0] pick_key();
        if (used_keys.size() > 0 && $urandom_range(0, 3) != 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        return $urandom();
    endfunction

    function automatic logic [kams_pkg::W_BITS-1:0] pick_weight();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return '0;
            default: return kams_pkg::W_BITS'($urandom());
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_words.size() > 0 || i_in_valid || expected_words.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_no_edge(logic signed [kams_pkg::W_BITS-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        g_no_edge = v;
        refill_matrix();
    endtask

    // A random phase: mostly edge inserts and listings, mixed, on keys mostly from a small pool.
    task automatic random_phase(int count);
        logic [2:0] op;
        int sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 19);
            if (sel <= 5) op = 3'(sel);
            else if ($urandom_range(0, 6) != 0)
                op = $urandom_range(0, 1) ? kams_pkg::OP_INS_EDGE : kams_pkg::OP_LIST;
            else if ($urandom_range(0, 1) != 0) op = 3'($urandom_range(6, 7));
            else op = 3'($urandom_range(0, 5));
            pending_words.push_back(make_word(op, pick_key(), pick_key(), pick_weight()));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = kams_pkg::NO_EDGE_RESET;
        g_no_edge = kams_pkg::NO_EDGE_RESET;
        refill_matrix();
        for (int i = 0; i < kams_pkg::MAX_V; i++) begin
            g_key[i] = '0;
            g_valid[i] = 1'b0;
            g_free[i] = kams_pkg::N_BITS'(i + 1);
        end
        g_head = 0;
        g_tail = 0;
        g_count = kams_pkg::MAX_V;
        for (int i = 0; i < 12; i++) used_keys.push_back($urandom());
        used_keys.push_back('0);
        used_keys.push_back('1);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: key extremes, every operation, self loop, missing keys.
        pending_words.push_back(make_word(kams_pkg::OP_LOOKUP, '0, '0, '0));
        pending_words.push_back(make_word(kams_pkg::OP_LIST, '1, '0, '0));
        pending_words.push_back(make_word(kams_pkg::OP_INS_EDGE, '0, '1, 16'h8000));
        pending_words.push_back(make_word(kams_pkg::OP_INS_EDGE, '1, '1, 16'h7ffe));
        pending_words.push_back(make_word(kams_pkg::OP_INS_EDGE, 32'h5a5a5a5a, 32'h5a5a5a5a,
                                          16'h0005));
        pending_words.push_back(make_word(kams_pkg::OP_INS_EDGE, '0, 32'h5a5a5a5a, 16'hffff));
        pending_words.push_back(make_word(kams_pkg::OP_INS_EDGE, '0, '0, 16'h7fff));
        pending_words.push_back(make_word(kams_pkg::OP_LIST, '0, '0, '0));
        pending_words.push_back(make_word(kams_pkg::OP_LIST, 32'h5a5a5a5a, '0, '0));
        pending_words.push_back(make_word(kams_pkg::OP_INS_VTX, 32'h0000_1234, '0, '0));
        pending_words.push_back(make_word(kams_pkg::OP_INS_VTX, 32'h0000_1234, '0, '0));
        pending_words.push_back(make_word(kams_pkg::OP_ERS_EDGE, '0, '1, '0));
        pending_words.push_back(make_word(kams_pkg::OP_ERS_EDGE, '0, 32'h7777, '0));
        pending_words.push_back(make_word(kams_pkg::OP_ERS_VTX, '1, '0, '0));
        pending_words.push_back(make_word(kams_pkg::OP_ERS_VTX, '1, '0, '0));
        pending_words.push_back(make_word(kams_pkg::OP_LIST, '0, '0, '0));
        pending_words.push_back(make_word(3'd6, '1, '1, 16'hffff));
        pending_words.push_back(make_word(3'd7, '0, '0, '0));
        // Fill the store to exhaust the free list.
        for (int i = 0; i < 15; i++)
            pending_words.push_back(make_word(kams_pkg::OP_INS_VTX, 32'hc000_0000 + i, '0, '0));
        pending_words.push_back(make_word(kams_pkg::OP_INS_EDGE, 32'hdead_0001, 32'hdead_0002,
                                          16'h0001));
        pending_words.push_back(make_word(kams_pkg::OP_INS_VTX, 32'hdead_0003, '0, '0));
        pending_words.push_back(make_word(kams_pkg::OP_INS_EDGE, '0, 32'hdead_0004, 16'h0002));
        wait_drained();
        // The sender holds off here with words queued, then is released.
        hold_send = 1'b1;
        for (int i = 0; i < 16; i++)
            pending_words.push_back(make_word(kams_pkg::OP_ERS_VTX,
                                              i < 15 ? 32'hc000_0000 + i : 32'h5a5a5a5a,
                                              '0, '0));
        repeat (20) @(posedge i_clk);
        hold_send = 1'b0;
        wait_drained();

        write_no_edge(16'sh8000);
        random_phase(30);
        wait_drained();
        write_no_edge(16'sd100);
        random_phase(30);
        wait_drained();
        write_no_edge(16'sd0);
        random_phase(25);
        wait_drained();
        write_no_edge(16'sh7fff);
        random_phase(30);
        wait_drained();
        write_no_edge(-16'sd5);
        random_phase(20);
        wait_drained();
        write_no_edge(16'sd32767);
        calm = 1'b1;
        random_phase(23);
        wait_drained();

        $display("Sent %0d request words and checked %0d result words, %0d of them neighbours,",
                 words_sent, words_seen, list_hits);
        $display("across six no-edge writes including both extremes.");
        if (mismatches == 0) begin
            $display("keyed_adjacency_matrix_store test passed");
        end else begin
            $display("keyed_adjacency_matrix_store test failed");
        end
        $finish;
    end
endmodule

>>> keyed_adjacency_matrix_store.f
design/kams_pkg.sv
design/kams_wmem.sv
design/kams_vtab.sv
design/keyed_adjacency_matrix_store.sv
tb/testbench.sv
